FILE: hw/rtl/lfc_pkg.sv
// Shared constants for the line/cylinder crossing pipeline.
// No dependencies; used by the top level.
package lfc_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_Z   = 2'd0,
    CFG_HALF_LEN   = 2'd1,
    CFG_DET_RADIUS = 2'd2
  } cfg_idx_e;

endpackage

FILE: hw/rtl/lfc_if.sv
// Handshake interfaces for line requests and crossing results.
// Depends on nothing; widths come from parameters.
interface lfc_req_if #(
  parameter int unsigned PW = 32,
  parameter int unsigned DW = 18
);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] start_x;
  logic signed [PW-1:0] start_y;
  logic signed [PW-1:0] start_z;
  logic signed [DW-1:0] dir_x;
  logic signed [DW-1:0] dir_y;
  logic signed [DW-1:0] dir_z;

  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface lfc_rsp_if;
  logic valid;
  logic ready;
  logic crosses;

  modport source (output valid, crosses, input ready);
  modport sink (input valid, crosses, output ready);
endinterface

FILE: hw/rtl/lfc_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// Standalone; used by the crossing top level.
module lfc_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  localparam int unsigned LA = WA / 2;
  localparam int unsigned LB = WB / 2;
  localparam int unsigned HA = WA - LA;
  localparam int unsigned HB = WB - LB;
  localparam int unsigned WP = WA + WB;

  logic signed [HA+HB-1:0]   hh_d, hh_q;
  logic signed [HA+LB:0]     hl_d, hl_q;
  logic signed [LA+HB:0]     lh_d, lh_q;
  logic signed [LA+LB+1:0]   ll_d, ll_q;
  logic signed [WP-1:0]      p_d, p_q;

  always_comb begin
    hh_d = $signed(a_i[WA-1:LA]) * $signed(b_i[WB-1:LB]);
    hl_d = $signed(a_i[WA-1:LA]) * $signed({1'b0, b_i[LB-1:0]});
    lh_d = $signed({1'b0, a_i[LA-1:0]}) * $signed(b_i[WB-1:LB]);
    ll_d = $signed({1'b0, a_i[LA-1:0]}) * $signed({1'b0, b_i[LB-1:0]});
    p_d  = (WP'(hh_q) <<< (LA + LB)) + (WP'(hl_q) <<< LA)
         + (WP'(lh_q) <<< LB) + WP'(ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;
endmodule

FILE: hw/rtl/lfc_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a sideband.
// Standalone; used by the crossing top level.
module lfc_sqrt #(
  parameter int unsigned SQ     = 52,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SQ-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SQ-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int unsigned RW = 2 * SQ;

  logic [SQ+1:0]     rem_q  [SQ];
  logic [SQ-1:0]     root_q [SQ];
  logic [RW-1:0]     rad_q  [SQ];
  logic [SIDE_W-1:0] side_q [SQ];
  logic [SQ-1:0]     vld_q;

  for (genvar k = 0; k < SQ; k++) begin : g_stage
    logic [SQ+1:0]     rem_in, rem_sh, trial;
    logic [SQ-1:0]     root_in;
    logic [RW-1:0]     rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in[SQ-1:0], rad_in[RW-1:RW-2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[RW-3:0], 2'b00};
        side_q[k] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[SQ-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[SQ-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[SQ-1];
  assign root_o  = root_q[SQ-1];
  assign side_o  = side_q[SQ-1];
endmodule

FILE: hw/rtl/line_finite_cylinder_crossing_core.sv
// Top level of the line versus finite z-aligned cylinder crossing test.
// Depends on lfc_pkg, lfc_if, lfc_mul and lfc_sqrt.
//
//   port     dir  handshake      payload
//   req_i    in   valid/ready    start_x/y/z, dir_x/y/z
//   rsp_o    out  valid/ready    crosses
//   cfg_*    in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One line per cycle while no result is stalled, through 10 + POS_WIDTH + FRAC_BITS + 4
// register stages, set by the one-bit-per-stage square root. Reset clears all valid
// bits and the configuration. A stalled result freezes the whole pipeline; nothing is lost.
module line_finite_cylinder_crossing_core #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lfc_req_if.sink              req_i,
  lfc_rsp_if.source            rsp_o,
  input  logic                 cfg_we_i,
  input  logic [lfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [POS_WIDTH-1:0] cfg_data_i
);
  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned DW = FRAC_BITS + 2;
  localparam int unsigned AW = 2 * DW + 1;
  localparam int unsigned HW = DW + PW + 1;
  localparam int unsigned CW = 2 * PW + 2;
  localparam int unsigned QW = AW + CW + 1;
  localparam int unsigned SQ = QW / 2;
  localparam int unsigned UW = 2 * DW + PW + 3;
  localparam int unsigned MW = AW + PW;
  localparam int unsigned XW = UW + 1;
  localparam int unsigned SIDE_W = 1 + DW + UW + MW;

  // Configuration registers.
  logic signed [PW-1:0] cz_q;
  logic [PW-2:0]        len_q;
  logic [PW-3:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cz_q  <= '0;
      len_q <= '0;
      rad_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lfc_pkg::CFG_CENTER_Z:   cz_q  <= cfg_data_i;
        lfc_pkg::CFG_HALF_LEN:   len_q <= cfg_data_i[PW-2:0];
        lfc_pkg::CFG_DET_RADIUS: rad_q <= cfg_data_i[PW-3:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q, out_c_q, out_c_d;
  assign en = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;

  // Stage 0: input registers.
  logic                 v0_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [DW-1:0] dx_q, dy_q, dz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= req_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= req_i.start_x;
      py_q  <= req_i.start_y;
      pz_q  <= req_i.start_z;
      dx_q  <= req_i.dir_x;
      dy_q  <= req_i.dir_y;
      dz0_q <= req_i.dir_z;
    end
  end

  // First multiplier rank.
  logic signed [2*DW-1:0]    dxx, dyy;
  logic signed [DW+PW-1:0]   dxpx, dypy;
  logic signed [2*PW-1:0]    pxx, pyy, rr;
  logic signed [PW-1:0]      r_s;
  assign r_s = $signed({1'b0, rad_q, 1'b0});

  lfc_mul #(.WA(DW), .WB(DW)) u_mul_dxx (.clk_i, .en_i(en), .a_i(dx_q), .b_i(dx_q), .p_o(dxx));
  lfc_mul #(.WA(DW), .WB(DW)) u_mul_dyy (.clk_i, .en_i(en), .a_i(dy_q), .b_i(dy_q), .p_o(dyy));
  lfc_mul #(.WA(DW), .WB(PW)) u_mul_dxpx (.clk_i, .en_i(en), .a_i(dx_q), .b_i(px_q),
                                          .p_o(dxpx));
  lfc_mul #(.WA(DW), .WB(PW)) u_mul_dypy (.clk_i, .en_i(en), .a_i(dy_q), .b_i(py_q),
                                          .p_o(dypy));
  lfc_mul #(.WA(PW), .WB(PW)) u_mul_pxx (.clk_i, .en_i(en), .a_i(px_q), .b_i(px_q), .p_o(pxx));
  lfc_mul #(.WA(PW), .WB(PW)) u_mul_pyy (.clk_i, .en_i(en), .a_i(py_q), .b_i(py_q), .p_o(pyy));
  lfc_mul #(.WA(PW), .WB(PW)) u_mul_rr (.clk_i, .en_i(en), .a_i(r_s), .b_i(r_s), .p_o(rr));

  // Side data across the first rank.
  logic [1:0]           v1_q, live1_q;
  logic signed [PW:0]   w1_q [2];
  logic signed [DW-1:0] dz1_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= '0;
    else if (en) v1_q <= {v1_q[0], v0_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      live1_q  <= {live1_q[0], dy_q != '0};
      w1_q[0]  <= (PW+1)'(pz_q) - (PW+1)'(cz_q);
      w1_q[1]  <= w1_q[0];
      dz1_q[0] <= dz0_q;
      dz1_q[1] <= dz1_q[0];
    end
  end

  // Stage 3: quadratic coefficients.
  logic                 v3_q, live3_q;
  logic signed [AW-1:0] a_q;
  logic signed [HW-1:0] h_q;
  logic signed [CW-1:0] c_q;
  logic signed [PW:0]   w3_q;
  logic signed [DW-1:0] dz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v1_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      live3_q <= live1_q[1];
      a_q     <= AW'(dxx) + AW'(dyy);
      h_q     <= HW'(dxpx) + HW'(dypy);
      c_q     <= CW'(pxx) + CW'(pyy) - CW'(rr);
      w3_q    <= w1_q[1];
      dz3_q   <= dz1_q[1];
    end
  end

  // Second multiplier rank.
  logic signed [2*HW-1:0]   hh;
  logic signed [AW+CW-1:0]  ac;
  logic signed [AW+PW:0]    aw;
  logic signed [DW+HW-1:0]  dzh;
  logic signed [AW+PW-1:0]  alen;
  logic signed [PW-1:0]     len_s;
  assign len_s = $signed({1'b0, len_q});

  lfc_mul #(.WA(HW), .WB(HW)) u_mul_hh (.clk_i, .en_i(en), .a_i(h_q), .b_i(h_q), .p_o(hh));
  lfc_mul #(.WA(AW), .WB(CW)) u_mul_ac (.clk_i, .en_i(en), .a_i(a_q), .b_i(c_q), .p_o(ac));
  lfc_mul #(.WA(AW), .WB(PW+1)) u_mul_aw (.clk_i, .en_i(en), .a_i(a_q), .b_i(w3_q), .p_o(aw));
  lfc_mul #(.WA(DW), .WB(HW)) u_mul_dzh (.clk_i, .en_i(en), .a_i(dz3_q), .b_i(h_q),
                                         .p_o(dzh));
  lfc_mul #(.WA(AW), .WB(PW)) u_mul_alen (.clk_i, .en_i(en), .a_i(a_q), .b_i(len_s),
                                          .p_o(alen));

  logic [1:0]           v4_q, live4_q;
  logic signed [DW-1:0] dz4_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= '0;
    else if (en) v4_q <= {v4_q[0], v3_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      live4_q  <= {live4_q[0], live3_q};
      dz4_q[0] <= dz3_q;
      dz4_q[1] <= dz4_q[0];
    end
  end

  // Stage 6: discriminant and the root-independent part of a*(z - centre).
  logic                 v6_q, live6_q;
  logic signed [QW-1:0] q_d;
  logic [QW-1:0]        rad6_q;
  logic signed [UW-1:0] u6_q;
  logic signed [MW-1:0] m6_q;
  logic signed [DW-1:0] dz6_q;

  assign q_d = QW'(hh) - QW'(ac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v4_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      live6_q <= live4_q[1] && !q_d[QW-1];
      rad6_q  <= q_d[QW-1] ? '0 : q_d;
      u6_q    <= UW'(aw) - UW'(dzh);
      m6_q    <= alen;
      dz6_q   <= dz4_q[1];
    end
  end

  // Square root of the discriminant.
  logic              vs;
  logic [SQ-1:0]     s_root;
  logic [SIDE_W-1:0] side_out;
  logic              live_s;
  logic signed [DW-1:0] dz_s;
  logic signed [UW-1:0] u_s;
  logic signed [MW-1:0] m_s;

  lfc_sqrt #(.SQ(SQ), .SIDE_W(SIDE_W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .rad_i(rad6_q),
    .side_i({live6_q, dz6_q, u6_q, m6_q}),
    .valid_o(vs), .root_o(s_root), .side_o(side_out)
  );

  assign {live_s, dz_s, u_s, m_s} = side_out;

  // Third multiplier rank: dz * floor(sqrt(Q)).
  logic signed [DW+SQ:0] v_prod;
  logic signed [SQ:0]    s_s;
  assign s_s = $signed({1'b0, s_root});

  lfc_mul #(.WA(DW), .WB(SQ+1)) u_mul_dzs (.clk_i, .en_i(en), .a_i(dz_s), .b_i(s_s),
                                           .p_o(v_prod));

  logic [1:0]           v7_q, live7_q;
  logic signed [UW-1:0] u7_q [2];
  logic signed [MW-1:0] m7_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= '0;
    else if (en) v7_q <= {v7_q[0], vs};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      live7_q <= {live7_q[0], live_s};
      u7_q[0] <= u_s;
      u7_q[1] <= u7_q[0];
      m7_q[0] <= m_s;
      m7_q[1] <= m7_q[0];
    end
  end

  // Final compare: either root strictly inside the half length.
  logic signed [XW-1:0] x_lo, x_hi, mm;
  always_comb begin
    x_lo    = XW'(u7_q[1]) - XW'(v_prod);
    x_hi    = XW'(u7_q[1]) + XW'(v_prod);
    mm      = XW'(m7_q[1]);
    out_c_d = live7_q[1] && (((x_lo < mm) && (-mm < x_lo)) ||
                             ((x_hi < mm) && (-mm < x_hi)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v7_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_c_q <= out_c_d;
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.crosses = out_c_q;

  // A waiting result must hold off new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted while result stalled");

  // Stalls freeze the middle of the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v3_q) && $stable(v6_q))
    else $error("pipeline moved during stall");

  // A line with a negative discriminant is never marked live.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && q_d[QW-1]) |=> !live6_q)
    else $error("negative discriminant kept live");
endmodule
